@@ rtl/core/csv_cell_tokenizer_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
// In synthesis builds the macros expand to nothing.
`ifndef CSV_CELL_TOKENIZER_DEFINES_SVH
`define CSV_CELL_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every clock edge outside reset.
`define CSVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("csv tokenizer check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define CSVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("csv tokenizer check failed");

`else

`define CSVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CSVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/core/csvt_pkg.sv @@
`timescale 1ns / 1ps

package csvt_pkg;

  // Result list size per input beat.
  localparam int ResMax  = 6;
  localparam int ResCntW = $clog2(ResMax + 1);
  localparam int ResIdxW = $clog2(ResMax);

  // Characters of interest.
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // UTF-8 byte order mark.
  localparam logic [7:0] BomByte0 = 8'hEF;
  localparam logic [7:0] BomByte1 = 8'hBB;
  localparam logic [7:0] BomByte2 = 8'hBF;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_ROW_END  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_STRAY_QUOTE = 2'd1,
    ERR_UNCLOSED    = 2'd2
  } err_t;

  // Parser state carried from beat to beat.
  typedef struct packed {
    logic       inside_quotes;
    logic       close_pending;
    logic       cell_quoted;
    logic       cell_has_bytes;
    logic       row_has_cells;
    logic [1:0] bom_count;
    logic       at_start;
    logic       error_seen;
  } state_t;

  localparam state_t StateReset = '{
    inside_quotes:  1'b0,
    close_pending:  1'b0,
    cell_quoted:    1'b0,
    cell_has_bytes: 1'b0,
    row_has_cells:  1'b0,
    bom_count:      2'd0,
    at_start:       1'b1,
    error_seen:     1'b0
  };

  // One result entry.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] cell_byte;
    err_t       err;
  } res_t;

  // Result list of one input beat, as handed to the result queue.
  typedef struct packed {
    res_t [ResMax-1:0]  res;
    logic [ResCntW-1:0] cnt;
    logic               eot;
  } step_t;

  // Working value while one beat is evaluated.
  typedef struct packed {
    state_t             st;
    res_t [ResMax-1:0]  res;
    logic [ResCntW-1:0] cnt;
  } acc_t;

  // Append one result; extra results beyond the list size are dropped.
  function automatic acc_t push_res(acc_t a, kind_t k, logic [7:0] b, err_t e);
    acc_t r;
    r = a;
    if (r.cnt < ResCntW'(ResMax)) begin
      r.res[r.cnt[ResIdxW-1:0]] = '{kind: k, cell_byte: b, err: e};
      r.cnt = r.cnt + ResCntW'(1);
    end
    return r;
  endfunction

  // Close the current row if it holds anything, then start a fresh one.
  function automatic acc_t close_row(acc_t a);
    acc_t r;
    r = a;
    if (r.st.row_has_cells || r.st.cell_has_bytes) begin
      r = push_res(r, KIND_CELL_END, 8'h00, ERR_NONE);
      r = push_res(r, KIND_ROW_END, 8'h00, ERR_NONE);
    end
    r.st.cell_has_bytes = 1'b0;
    r.st.cell_quoted    = 1'b0;
    r.st.row_has_cells  = 1'b0;
    return r;
  endfunction

  // Run one text byte through the quoting rules.
  function automatic acc_t feed(acc_t a, logic [7:0] c);
    acc_t r;
    logic plain;
    r = a;
    plain = 1'b0;
    if (!r.st.error_seen) begin
      if (r.st.inside_quotes) begin
        if (r.st.close_pending) begin
          // A quote right after a quote is a literal; anything else ends quoting.
          r.st.close_pending = 1'b0;
          if (c == ChQuote) begin
            r = push_res(r, KIND_BYTE, c, ERR_NONE);
            r.st.cell_has_bytes = 1'b1;
          end else begin
            r.st.inside_quotes = 1'b0;
            plain = 1'b1;
          end
        end else if (c == ChQuote) begin
          r.st.close_pending = 1'b1;
        end else begin
          r = push_res(r, KIND_BYTE, c, ERR_NONE);
          r.st.cell_has_bytes = 1'b1;
        end
      end else begin
        plain = 1'b1;
      end

      if (plain) begin
        case (c)
          ChQuote: begin
            if (!r.st.cell_has_bytes && !r.st.cell_quoted) begin
              r.st.inside_quotes = 1'b1;
              r.st.cell_quoted   = 1'b1;
            end else begin
              r = push_res(r, KIND_ERROR, 8'h00, ERR_STRAY_QUOTE);
              r.st.error_seen = 1'b1;
            end
          end
          ChComma: begin
            r = push_res(r, KIND_CELL_END, 8'h00, ERR_NONE);
            r.st.row_has_cells  = 1'b1;
            r.st.cell_has_bytes = 1'b0;
            r.st.cell_quoted    = 1'b0;
          end
          ChCr: begin
            r.st.error_seen = r.st.error_seen;
          end
          ChLf: begin
            r = close_row(r);
          end
          default: begin
            r = push_res(r, KIND_BYTE, c, ERR_NONE);
            r.st.cell_has_bytes = 1'b1;
          end
        endcase
      end
    end
    return r;
  endfunction

  // Replay the held byte order mark bytes as ordinary text.
  function automatic acc_t replay_held(acc_t a);
    acc_t r;
    r = a;
    if (r.st.bom_count >= 2'd1) begin
      r = feed(r, BomByte0);
    end
    if (r.st.bom_count >= 2'd2) begin
      r = feed(r, BomByte1);
    end
    r.st.bom_count = 2'd0;
    r.st.at_start  = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/csvt_step.sv @@
`timescale 1ns / 1ps

// Evaluates one input beat against the parser state: the result list and
// the state that follows it.
module csvt_step
  import csvt_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] data_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  output step_t      step_o,
  output state_t     state_nxt_o
);

  acc_t       acc;
  logic [7:0] expected;

  // Next byte of the byte order mark that would continue the match.
  always_comb begin
    case (state_i.bom_count)
      2'd0:    expected = BomByte0;
      2'd1:    expected = BomByte1;
      default: expected = BomByte2;
    endcase
  end

  always_comb begin
    acc     = '0;
    acc.st  = state_i;
    acc.cnt = '0;

    // Byte handling, with the byte order mark filter at text start.
    if (byte_present_i && !acc.st.error_seen) begin
      if (acc.st.at_start) begin
        if (data_byte_i == expected) begin
          if (acc.st.bom_count == 2'd2) begin
            acc.st.bom_count = 2'd0;
            acc.st.at_start  = 1'b0;
          end else begin
            acc.st.bom_count = acc.st.bom_count + 2'd1;
          end
        end else begin
          acc = replay_held(acc);
          acc = feed(acc, data_byte_i);
        end
      end else begin
        acc = feed(acc, data_byte_i);
      end
    end

    // End of text: flush held bytes, flag an open quote or close the row.
    if (end_of_text_i && !acc.st.error_seen) begin
      if (acc.st.at_start) begin
        acc = replay_held(acc);
      end
      if (!acc.st.error_seen) begin
        if (acc.st.inside_quotes && !acc.st.close_pending) begin
          acc = push_res(acc, KIND_ERROR, 8'h00, ERR_UNCLOSED);
        end else begin
          acc = close_row(acc);
        end
      end
    end
  end

  assign step_o.res  = acc.res;
  assign step_o.cnt  = acc.cnt;
  assign step_o.eot  = end_of_text_i;
  assign state_nxt_o = end_of_text_i ? StateReset : acc.st;

endmodule

@@ rtl/core/csvt_result_queue.sv @@
`timescale 1ns / 1ps

// Holds the result list of one beat and hands it out one result per beat.
module csvt_result_queue
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  step_t      step_i,
  output logic       free_o,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_cell_byte,
  output logic [1:0] out_err_code,
  output logic       out_text_done,
  output logic       out_last_of_run
);

  res_t [ResMax-1:0]  res_r, res_nxt;
  logic [ResCntW-1:0] cnt_r, cnt_nxt;
  logic [ResIdxW-1:0] idx_r, idx_nxt;
  logic               eot_r, eot_nxt;
  logic               beat;
  logic               last;
  res_t               head;

  // Head of the list and the end-of-list flag.
  assign head      = res_r[idx_r];
  assign last      = (ResCntW'(idx_r) == cnt_r - ResCntW'(1));
  assign out_valid = (cnt_r != '0);
  assign beat      = out_valid && !out_stall;
  assign free_o    = !out_valid || (beat && last);

  assign out_result_kind = head.kind;
  assign out_cell_byte   = head.cell_byte;
  assign out_err_code    = head.err;
  assign out_last_of_run = last;
  assign out_text_done   = last && eot_r;

  // Load a fresh list when free, otherwise step through the current one.
  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    eot_nxt = eot_r;
    if (load_i) begin
      res_nxt = step_i.res;
      cnt_nxt = step_i.cnt;
      idx_nxt = '0;
      eot_nxt = step_i.eot;
    end else if (beat) begin
      if (last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + ResIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    eot_r <= eot_nxt;
  end

endmodule

@@ rtl/core/csv_cell_tokenizer.sv @@
// Path: a byte accepted into the input register moves on into the result queue
// once the queue is free, and its results are offered from that queue.
// Throughput: one byte per cycle while each byte causes at most one result and out_stall
// is low; the results of a byte leave the result queue one result per cycle while
// out_stall is low; the input stalls in between. Bytes with no result pass at one per cycle.
// Reset (rst_n low, synchronous) empties the input and result registers and
// sets the parser state to start of text.
`timescale 1ns / 1ps
`include "csv_cell_tokenizer_defines.svh"

module csv_cell_tokenizer
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_cell_byte,
  output logic [1:0] out_err_code,
  output logic       out_text_done,
  output logic       out_last_of_run
);

  logic       item_v_r, item_v_nxt;
  logic [7:0] byte_r;
  logic       present_r;
  logic       eot_r;
  state_t     state_r, state_nxt;
  step_t      step;
  logic       q_free;
  logic       load;
  logic       in_beat;

  // Input register: held while the result queue is still busy.
  assign load     = item_v_r && q_free;
  assign in_stall = item_v_r && !q_free;
  assign in_beat  = in_valid && !in_stall;

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_beat) begin
      item_v_nxt = 1'b1;
    end else if (load) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      byte_r    <= in_data_byte;
      present_r <= in_byte_present;
      eot_r     <= in_end_of_text;
    end
  end

  // Parser evaluation for the held byte.
  csvt_step u_step (
    .state_i        (state_r),
    .data_byte_i    (byte_r),
    .byte_present_i (present_r),
    .end_of_text_i  (eot_r),
    .step_o         (step),
    .state_nxt_o    (state_nxt)
  );

  // Parser state advances when a byte moves into the result queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

  csvt_result_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .load_i          (load),
    .step_i          (step),
    .free_o          (q_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_cell_byte   (out_cell_byte),
    .out_err_code    (out_err_code),
    .out_text_done   (out_text_done),
    .out_last_of_run (out_last_of_run)
  );

  // End of text always returns the parser to start of text.
  `CSVT_ASSERT_NEXT(a_eot_resets_state, clk, rst_n, load && eot_r, state_r == StateReset)
  // Results of one byte leave back to back.
  `CSVT_ASSERT_NEXT(a_run_contiguous, clk, rst_n, out_valid && !out_stall && !out_last_of_run, out_valid)
  // The input is only held back behind a byte waiting in the input register.
  `CSVT_ASSERT_IMPL(a_stall_has_item, clk, rst_n, in_stall, item_v_r && out_valid)

endmodule

@@ tb/csv_cell_tokenizer_tb.sv @@
`timescale 1ns / 1ps

module csv_cell_tokenizer_tb;
  import csvt_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_byte_present;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_result_kind;
  logic [7:0] out_cell_byte;
  logic [1:0] out_err_code;
  logic       out_text_done;
  logic       out_last_of_run;

  // One token that the tokenizer is expected to emit.
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    err_t       err;
    logic       is_done;
    logic       is_last;
  } token_t;

  token_t expected_tokens[$];
  token_t beat_tokens[$];

  // Shadow copy of the parser state.
  logic       quoted_mode;
  logic       quote_closing;
  logic       cell_quoted;
  logic       cell_nonempty;
  logic       row_open;
  logic [1:0] bom_held;
  logic       text_start;
  logic       halted;

  int  mismatches = 0;
  int  beats_sent = 0;
  int  hold_request = 0;
  bit  no_idle = 1'b0;

  csv_cell_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_present (in_byte_present),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_cell_byte   (out_cell_byte),
    .out_err_code    (out_err_code),
    .out_text_done   (out_text_done),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Parser state at start of text.
  function automatic void reset_parser();
    quoted_mode   = 1'b0;
    quote_closing = 1'b0;
    cell_quoted   = 1'b0;
    cell_nonempty = 1'b0;
    row_open      = 1'b0;
    bom_held      = 2'd0;
    text_start    = 1'b1;
    halted        = 1'b0;
  endfunction

  // The block keeps at most ResMax tokens per beat.
  function automatic void emit(kind_t k, logic [7:0] d, err_t e);
    token_t t;
    t.kind    = k;
    t.data    = d;
    t.err     = e;
    t.is_done = 1'b0;
    t.is_last = 1'b0;
    if (beat_tokens.size() < ResMax) beat_tokens.insert(beat_tokens.size(), t);
  endfunction

  // Close the row only if it holds a cell or cell bytes.
  function automatic void end_row();
    if (row_open || cell_nonempty) begin
      emit(KIND_CELL_END, 8'h00, ERR_NONE);
      emit(KIND_ROW_END, 8'h00, ERR_NONE);
    end
    cell_nonempty = 1'b0;
    cell_quoted   = 1'b0;
    row_open      = 1'b0;
  endfunction

  // Quoting rules for one text character.
  function automatic void parse_char(logic [7:0] c);
    if (halted) return;
    if (quoted_mode) begin
      if (quote_closing) begin
        quote_closing = 1'b0;
        if (c == ChQuote) begin
          emit(KIND_BYTE, c, ERR_NONE);
          cell_nonempty = 1'b1;
          return;
        end
        quoted_mode = 1'b0;
      end else begin
        if (c == ChQuote) begin
          quote_closing = 1'b1;
        end else begin
          emit(KIND_BYTE, c, ERR_NONE);
          cell_nonempty = 1'b1;
        end
        return;
      end
    end
    case (c)
      ChQuote: begin
        if (!cell_nonempty && !cell_quoted) begin
          quoted_mode = 1'b1;
          cell_quoted = 1'b1;
        end else begin
          emit(KIND_ERROR, 8'h00, ERR_STRAY_QUOTE);
          halted = 1'b1;
        end
      end
      ChComma: begin
        emit(KIND_CELL_END, 8'h00, ERR_NONE);
        row_open      = 1'b1;
        cell_nonempty = 1'b0;
        cell_quoted   = 1'b0;
      end
      ChCr: begin
      end
      ChLf: begin
        end_row();
      end
      default: begin
        emit(KIND_BYTE, c, ERR_NONE);
        cell_nonempty = 1'b1;
      end
    endcase
  endfunction

  // Held byte order mark bytes turn out to be plain text.
  function automatic void replay_bom();
    if (bom_held >= 2'd1) parse_char(BomByte0);
    if (bom_held >= 2'd2) parse_char(BomByte1);
    bom_held   = 2'd0;
    text_start = 1'b0;
  endfunction

  // Work out the tokens of one accepted beat and queue them.
  function automatic void tokenize_beat(logic [7:0] d, logic present, logic eot);
    logic [7:0] want;
    token_t     t;
    beat_tokens.delete();
    if (present && !halted) begin
      if (text_start) begin
        want = (bom_held == 2'd0) ? BomByte0 : (bom_held == 2'd1) ? BomByte1 : BomByte2;
        if (d == want) begin
          bom_held = bom_held + 2'd1;
          if (bom_held == 2'd3) begin
            bom_held   = 2'd0;
            text_start = 1'b0;
          end
        end else begin
          replay_bom();
          parse_char(d);
        end
      end else begin
        parse_char(d);
      end
    end
    if (eot && !halted) begin
      if (text_start) replay_bom();
      if (!halted) begin
        if (quoted_mode && !quote_closing) emit(KIND_ERROR, 8'h00, ERR_UNCLOSED);
        else end_row();
      end
    end
    for (int i = 0; i < beat_tokens.size(); i++) begin
      t         = beat_tokens[i];
      t.is_last = (i == beat_tokens.size() - 1);
      t.is_done = t.is_last && eot;
      expected_tokens.insert(expected_tokens.size(), t);
    end
    if (eot) reset_parser();
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Characters that steer the parser, mixed with arbitrary bytes.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return ChQuote;
      1: return ChComma;
      2: return ChCr;
      3: return ChLf;
      4: return BomByte0;
      5: return BomByte1;
      6: return BomByte2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Any byte that is not a delimiter.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == ChQuote || c == ChComma || c == ChCr || c == ChLf) c = 8'h61;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t: mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Send one input beat; returns at the edge that accepts it.
  task automatic send_beat(logic [7:0] d, logic present, logic eot);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_byte_present <= present;
    in_end_of_text  <= eot;
    do @(posedge clk); while (in_stall);
    tokenize_beat(d, present, eot);
    beats_sent++;
  endtask

  // A well-formed CSV text with random content, optionally with one byte spoiled.
  task automatic send_csv_text(bit corrupt, int max_rows);
    logic [7:0] text[$];
    logic [7:0] ch;
    int         rows;
    int         cols;
    int         len;
    bit         eot_on_last;
    case ($urandom_range(0, 4))
      1: text = {BomByte0, BomByte1, BomByte2};
      2: text = {BomByte0};
      3: text = {BomByte0, BomByte1};
      default: text = {};
    endcase
    rows = $urandom_range(1, max_rows);
    for (int r = 0; r < rows; r++) begin
      cols = $urandom_range(1, 3);
      for (int k = 0; k < cols; k++) begin
        if (k > 0) text.insert(text.size(), ChComma);
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 1)) begin
          text.insert(text.size(), ChQuote);
          for (int j = 0; j < len; j++) begin
            ch = pick_char();
            text.insert(text.size(), ch);
            if (ch == ChQuote) text.insert(text.size(), ChQuote);
          end
          text.insert(text.size(), ChQuote);
        end else begin
          for (int j = 0; j < len; j++) text.insert(text.size(), plain_char());
        end
      end
      // Row ends in LF or CR LF; the last row may stay open; sometimes an empty line follows.
      case ($urandom_range(0, 3))
        0: text = {text, ChCr, ChLf};
        3: if (r != rows - 1) text.insert(text.size(), ChLf);
        default: text.insert(text.size(), ChLf);
      endcase
      if ($urandom_range(0, 5) == 0) text.insert(text.size(), ChLf);
    end
    if (corrupt && text.size() > 0) text[$urandom_range(0, text.size() - 1)] = pick_char();
    eot_on_last = $urandom_range(0, 1);
    foreach (text[i]) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(text[i], 1'b1, eot_on_last && (i == text.size() - 1));
    end
    if (!eot_on_last || text.size() == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Arbitrary beats, closed by an end of text.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) send_beat(pick_char(), $urandom_range(0, 4) != 0, $urandom_range(0, 9) == 0);
    send_beat(pick_char(), 1'(($urandom_range(0, 1))), 1'b1);
  endtask

  // Full mark, quoted cell with a doubled quote, text after a closing quote, CR dropped.
  task automatic test_bom_and_quoting();
    send_beat(BomByte0, 1'b1, 1'b0);
    send_beat(BomByte1, 1'b1, 1'b0);
    send_beat(BomByte2, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(8'h78, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(8'h7A, 1'b1, 1'b0);
    send_beat(ChComma, 1'b1, 1'b0);
    send_beat(ChCr, 1'b1, 1'b0);
    send_beat(ChLf, 1'b1, 1'b1);
  endtask

  // Partial marks are replayed as text, also when the text ends while they are held.
  task automatic test_held_mark_replay();
    send_beat(BomByte0, 1'b1, 1'b0);
    send_beat(BomByte1, 1'b1, 1'b0);
    send_beat(ChComma, 1'b1, 1'b1);
    send_beat(BomByte0, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
  endtask

  // Empty lines, a lone pair of quotes and bare markers emit nothing.
  task automatic test_empty_lines();
    send_beat(ChLf, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(ChCr, 1'b1, 1'b0);
    send_beat(ChLf, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // Stray quote, bytes ignored after it, and an unclosed quote at the end.
  task automatic test_error_handling();
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(ChQuote, 1'b1, 1'b0);
    send_beat(8'h71, 1'b1, 1'b1);
  endtask

  task automatic test_random_texts(int count);
    int stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_csv_text($urandom_range(0, 5) == 0, 3);
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off for a long stretch while texts keep coming.
  task automatic test_backpressure();
    no_idle      = 1'b1;
    hold_request = 250;
    repeat (3) send_csv_text(1'b0, 4);
    no_idle = 1'b0;
  endtask

  // Result side: random stalls per beat, plus the long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        n            = hold_request;
        hold_request = 0;
      end else begin
        n = draw_gap();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every accepted result with the oldest expected token.
  always @(posedge clk) begin : check_results
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected result kind", out_result_kind, -1);
      end else begin
        want = expected_tokens.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch("result_kind", out_result_kind, want.kind);
        if (out_cell_byte !== want.data)
          report_mismatch("cell_byte", out_cell_byte, want.data);
        if (out_err_code !== want.err)
          report_mismatch("err_code", out_err_code, want.err);
        if (out_text_done !== want.is_done)
          report_mismatch("text_done", out_text_done, want.is_done);
        if (out_last_of_run !== want.is_last)
          report_mismatch("last_of_run", out_last_of_run, want.is_last);
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = 8'h00;
    in_byte_present = 1'b0;
    in_end_of_text  = 1'b0;
    reset_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_bom_and_quoting();
    test_held_mark_replay();
    test_empty_lines();
    test_error_handling();
    test_random_texts(110);
    test_backpressure();

    // Drain the result queue, then allow for trailing results.
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[csv_cell_tokenizer] OK");
    end else begin
      $display("[csv_cell_tokenizer] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("[csv_cell_tokenizer] ERROR");
    $finish;
  end

endmodule
